/* sv/tccw_pkg.sv */
// shared types, constants and sizes for the text console cell writer
package tccw_pkg;

  // store geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;

  // reciprocal for index / COLUMNS, exact for any 11-bit index
  localparam int IDX_W     = 11;
  localparam int ROW_SHIFT = IDX_W + $clog2(COLUMNS);
  localparam int ROW_RECIP = ((2 ** ROW_SHIFT) + COLUMNS - 1) / COLUMNS;

  // character and attribute codes
  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] ATTR_RESET   = 8'h0F;

  // result status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  // configuration register map
  localparam int          CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] ADDR_ATTR = 3'd0;

  // request kinds
  typedef enum logic [1:0] {
    REQ_PUT  = 2'd0,
    REQ_SEEK = 2'd1,
    REQ_READ = 2'd2
  } req_t;

  // result fields carried from the store access to the output stage
  typedef struct packed {
    logic        status;
    logic        written;
    logic        is_read;
    logic [10:0] addr;
    logic [10:0] cursor;
  } res_t;

endpackage

/* sv/text_console_cell_writer.sv */
// text console cell writer: cursor logic, cell store and result pipeline
//
// Usage: requests enter on the in_ channel (valid/stall), one result per
// request leaves on the out_ channel in request order. A put writes the
// character at the cursor with the current attribute and advances the cursor;
// a newline byte moves to the start of the next row. A seek moves the cursor,
// a read returns one cell. The attribute is set through the APB port at
// byte address 0 and may only be changed while no request is in flight.
// One request is accepted per cycle while in_stall is low: the cell store is
// a dual-port RAM with one write and one read per cycle, and the cursor update
// fits in that cycle. A result passes from acceptance through the store stage,
// with its registered RAM read, and the output register to out_valid.
// After reset the store is cleared one cell per cycle, all CELL_COUNT cells
// (2000 for 80x25); in_stall stays high during the sweep while APB writes
// are still taken. When out_stall is high the output holds; one more request
// is absorbed by the store stage before in_stall rises.
module text_console_cell_writer (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_req_type,
  input  logic [7:0]                  in_char_code,
  input  logic [10:0]                 in_cell_index,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_status,
  output logic                        out_cell_written,
  output logic [10:0]                 out_cell_addr,
  output logic [7:0]                  out_char_out,
  output logic [7:0]                  out_attr_out,
  output logic [10:0]                 out_cursor_pos,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tccw_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import tccw_pkg::*;

  logic [15:0]       cell_mem [CELL_COUNT];
  logic [15:0]       ram_q_r;

  logic [7:0]        attr_r;
  logic              clearing_r;
  logic [ADDR_W-1:0] clr_cnt_r;

  logic [ADDR_W-1:0] cursor_r, cursor_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;

  logic              s1_valid_r;
  res_t              s1_r, res_nxt;

  logic              out_valid_r;
  res_t              out_r;
  logic [15:0]       out_cell_r;

  logic              accept, advance;
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [15:0]       wr_data;
  logic [31:0]       row_base, next_row, cursor_inc, seek_prod;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_ATTR) ? {24'd0, attr_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_ATTR) begin
      attr_r <= pwdata[7:0];
    end
  end

  // handshake
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = clearing_r || (s1_valid_r && !advance);
  assign accept   = in_valid && !in_stall;

  // cursor arithmetic and result of the incoming request
  always_comb begin
    row_base   = 32'(row_r) * 32'(COLUMNS);
    next_row   = row_base + 32'(COLUMNS);
    cursor_inc = 32'(cursor_r) + 32'd1;
    seek_prod  = 32'(in_cell_index) * 32'(ROW_RECIP);

    cursor_nxt      = cursor_r;
    row_nxt         = row_r;
    rd_en           = 1'b0;
    rd_addr         = ADDR_W'(in_cell_index);
    res_nxt.status  = STATUS_RANGE;
    res_nxt.written = 1'b0;
    res_nxt.is_read = 1'b0;
    res_nxt.addr    = 11'd0;
    wr_en           = 1'b0;

    unique case (req_t'(in_req_type))
      REQ_PUT: begin
        if (in_char_code == NEWLINE_CODE) begin
          if (next_row < 32'(CELL_COUNT)) begin
            cursor_nxt     = ADDR_W'(next_row);
            row_nxt        = row_r + ROW_W'(1);
            res_nxt.status = STATUS_OK;
          end
        end else begin
          wr_en           = 1'b1;
          res_nxt.written = 1'b1;
          res_nxt.addr    = 11'(cursor_r);
          if (cursor_inc < 32'(CELL_COUNT)) begin
            cursor_nxt     = ADDR_W'(cursor_inc);
            res_nxt.status = STATUS_OK;
            if (cursor_inc == next_row) begin
              row_nxt = row_r + ROW_W'(1);
            end
          end
        end
      end
      REQ_SEEK: begin
        if (32'(in_cell_index) < 32'(CELL_COUNT)) begin
          cursor_nxt     = ADDR_W'(in_cell_index);
          row_nxt        = ROW_W'(seek_prod >> ROW_SHIFT);
          res_nxt.status = STATUS_OK;
        end
      end
      REQ_READ: begin
        if (32'(in_cell_index) < 32'(CELL_COUNT)) begin
          rd_en           = 1'b1;
          res_nxt.is_read = 1'b1;
          res_nxt.addr    = in_cell_index;
          res_nxt.status  = STATUS_OK;
        end
      end
      default: begin
      end
    endcase

    res_nxt.cursor = 11'(cursor_nxt);
  end

  // store write port: clearing sweep or put
  always_comb begin
    if (clearing_r) begin
      wr_addr = clr_cnt_r;
      wr_data = 16'd0;
    end else begin
      wr_addr = cursor_r;
      wr_data = {attr_r, in_char_code};
    end
  end

  // cell store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (clearing_r || (accept && wr_en)) begin
      cell_mem[wr_addr] <= wr_data;
    end
    if (accept && rd_en) begin
      ram_q_r <= cell_mem[rd_addr];
    end
  end

  // clearing sweep after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      if (32'(clr_cnt_r) == 32'(CELL_COUNT - 1)) begin
        clearing_r <= 1'b0;
      end
      clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
    end
  end

  // cursor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
      row_r    <= '0;
    end else if (accept) begin
      cursor_r <= cursor_nxt;
      row_r    <= row_nxt;
    end
  end

  // store stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= res_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r      <= s1_r;
      out_cell_r <= s1_r.is_read ? ram_q_r : 16'd0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_r.status;
  assign out_cell_written = out_r.written;
  assign out_cell_addr    = out_r.addr;
  assign out_char_out     = out_cell_r[7:0];
  assign out_attr_out     = out_cell_r[15:8];
  assign out_cursor_pos   = out_r.cursor;

endmodule

/* sv/tccw_checker.sv */
// port-level checker for the text console cell writer, with its bind
module tccw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_status,
  input logic        out_cell_written,
  input logic [10:0] out_cell_addr,
  input logic [7:0]  out_char_out,
  input logic [7:0]  out_attr_out,
  input logic [10:0] out_cursor_pos
);

  // reset empties the pipeline and starts the clearing sweep
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("pipeline not idle or not clearing after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_cell_addr) && $stable(out_char_out)
      && $stable(out_cursor_pos))
    else $error("stalled result changed");

  // cell data only comes back from a successful read
  a_read_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_char_out != 8'd0 || out_attr_out != 8'd0)
      |-> !out_cell_written && !out_status)
    else $error("cell data on a result that is not a read");

  // a successful put advances the cursor past the written cell
  a_put_advance: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cell_written && !out_status
      |-> out_cursor_pos == out_cell_addr + 11'd1)
    else $error("cursor did not advance after a put");

  // a put on the last cell leaves the cursor on it
  a_put_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cell_written && out_status
      |-> out_cursor_pos == out_cell_addr)
    else $error("cursor moved after a put on the last cell");

endmodule

bind text_console_cell_writer tccw_checker u_tccw_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_status       (out_status),
  .out_cell_written (out_cell_written),
  .out_cell_addr    (out_cell_addr),
  .out_char_out     (out_char_out),
  .out_attr_out     (out_attr_out),
  .out_cursor_pos   (out_cursor_pos)
);
